>>> design/rfks_pkg.sv
package rfks_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int KEY_W = 31;
    localparam int AGE_W = 8;
    localparam int FEE_W = 32;

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_SRCH = 2'd2;
    localparam logic [1:0] ACT_CLR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [FEE_W-1:0] fee;
    } rec_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

>>> design/record_fifo_with_key_search.sv
// Channel | Handshake           | Words
// --------+---------------------+------------------------------------------------
// in      | in_valid / in_stall | action, key, age, fee_bits
// out     | out_valid/out_stall | status, rec_key, rec_age, rec_fee_bits, occupancy
//
// Enqueue, dequeue, clear and a search of an empty queue finish in the cycle
// of acceptance; a new word can follow in the next cycle unless the held result is stalled.
// A search of a non-empty queue rotates the whole cell chain once past the
// compare at cell 0, then registers the result when the turn ends.
// Reset clears count, state and the output register; the cells are not cleared.
// in_stall is high during a search and while a held result is stalled.
module record_fifo_with_key_search
    import rfks_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [KEY_W-1:0] key,
    input  logic [AGE_W-1:0] age,
    input  logic [FEE_W-1:0] fee_bits,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       status,
    output logic [KEY_W-1:0] rec_key,
    output logic [AGE_W-1:0] rec_age,
    output logic [FEE_W-1:0] rec_fee_bits,
    output logic [CNT_W-1:0] occupancy
);

    typedef enum logic {S_IDLE, S_SEARCH} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic             hit_reg, hit_next;
    rec_t             found_reg, found_next;
    logic [KEY_W-1:0] skey_reg, skey_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    rec_t             out_rec_reg, out_rec_next;
    logic [CNT_W-1:0] out_occ_reg, out_occ_next;

    logic       accept;
    logic       take;
    logic       full;
    logic       empty;
    logic       hit_now;
    rec_t       in_rec;
    rec_t       cells [QUEUE_DEPTH];
    cell_ctrl_t ctrl  [QUEUE_DEPTH];

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign take     = out_valid_reg && !out_stall;
    assign full     = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign in_rec.key = key;
    assign in_rec.age = age;
    assign in_rec.fee = fee_bits;

    // only entries inside the current count may match
    assign hit_now = !hit_reg && (CNT_W'(step_reg) < count_reg)
                     && (cells[0].key == skey_reg);

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        localparam int NB = (i + 1) % QUEUE_DEPTH;

        always_comb
        begin
            ctrl[i].shift = (state_reg == S_SEARCH)
                            || (accept && action == ACT_DEQ && !empty);
            ctrl[i].load  = accept && action == ACT_ENQ && !full
                            && (count_reg == CNT_W'(i));
        end

        rfks_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl[i]),
            .load_rec (in_rec),
            .nb_rec   (cells[NB]),
            .rec      (cells[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        skey_next       = skey_reg;
        out_valid_next  = take ? 1'b0 : out_valid_reg;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_occ_next    = out_occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_rec_next    = '0;
                    unique case (action)
                        ACT_ENQ:
                        begin
                            if (full)
                                out_status_next = ST_FULL;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        ACT_DEQ:
                        begin
                            if (empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_rec_next = cells[0];
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        ACT_SRCH:
                        begin
                            if (empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // hold the result back until the rotation ends
                                out_valid_next = 1'b0;
                                state_next     = S_SEARCH;
                                step_next      = '0;
                                hit_next       = 1'b0;
                                skey_next      = key;
                            end
                        end
                        ACT_CLR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    out_occ_next = count_next;
                end
            end
            S_SEARCH:
            begin
                step_next = step_reg + 1'b1;
                if (hit_now)
                begin
                    hit_next   = 1'b1;
                    found_next = cells[0];
                end
                // a full turn brings the chain back to head order
                if (step_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = (hit_reg || hit_now) ? ST_OK : ST_NOTFOUND;
                    out_rec_next    = hit_now ? cells[0] : (hit_reg ? found_reg : '0);
                    out_occ_next    = count_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            hit_reg        <= 1'b0;
            found_reg      <= '0;
            skey_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_rec_reg    <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            hit_reg        <= hit_next;
            found_reg      <= found_next;
            skey_reg       <= skey_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rec_reg    <= out_rec_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign rec_key      = out_rec_reg.key;
    assign rec_age      = out_rec_reg.age;
    assign rec_fee_bits = out_rec_reg.fee;
    assign occupancy    = out_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("record count above queue depth");

    a_search_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |=> $stable(count_reg))
        else $error("count changed during a search");

    a_search_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && step_reg != IDX_W'(QUEUE_DEPTH - 1)) |=> !out_valid_reg)
        else $error("result shown before the search finished");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_NOTFOUND || out_status_reg == ST_EMPTY
                           || out_status_reg == ST_FULL)) |-> (out_rec_reg == '0))
        else $error("record fields not zero on a failed action");

endmodule

>>> design/rfks_cell.sv
module rfks_cell
    import rfks_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  rec_t       load_rec,
    input  rec_t       nb_rec,
    output rec_t       rec
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            rec_next = load_rec;
        end
        else if (ctrl.shift)
        begin
            // take the word of the cell behind, one step toward the head
            rec_next = nb_rec;
        end
        else
        begin
            rec_next = rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule
